@@ hw/rtl/tap_pkg.sv @@
// Shared types, constants and tables for the torsion atom placement block.
package tap_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int COEF_W         = 24;
    localparam int VEC_W          = 32;
    localparam int TORSION_W      = 16;
    localparam int CFG_IDX_W      = 8;
    localparam int CORDIC_W       = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_U       = 8'd0,
        REG_COEF_V_CONST = 8'd1,
        REG_COEF_V_COS   = 8'd2,
        REG_COEF_CROSS   = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] u_x;
        logic signed [VEC_W-1:0] u_y;
        logic signed [VEC_W-1:0] u_z;
        logic signed [VEC_W-1:0] v_x;
        logic signed [VEC_W-1:0] v_y;
        logic signed [VEC_W-1:0] v_z;
    } vec_t;

    typedef struct packed {
        vec_t                  vec;
        logic [TORSION_W-1:0]  torsion;
    } item_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_u;
        logic signed [COEF_W-1:0] coef_v_const;
        logic signed [COEF_W-1:0] coef_v_cos;
        logic signed [COEF_W-1:0] coef_cross;
    } coef_t;

    // arctangent of 2^-i in 2^-32 turns
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        case (idx)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10679838;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/tap_front.sv @@
// Input side: accepts items into a two-entry queue feeding the back end.
module tap_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  tap_pkg::item_t in_item,
    output logic           head_valid,
    input  logic           head_take,
    output tap_pkg::item_t head_item
);

    tap_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (count_reg != 2'd0);
    assign pop        = head_valid && head_take;
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue push lost");
    a_pop_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1))
        else $error("queue pop lost");
`endif

endmodule

@@ hw/rtl/tap_cordic.sv @@
// Pipelined rotation-mode CORDIC giving -cos and -sin, vectors carried along.
module tap_cordic
#(
    parameter int ITERS = tap_pkg::ANGLE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  tap_pkg::item_t                       in_item,
    output logic                                 out_valid,
    output logic signed [tap_pkg::CORDIC_W-1:0]  out_x,
    output logic signed [tap_pkg::CORDIC_W-1:0]  out_y,
    output logic                                 out_flip,
    output tap_pkg::vec_t                        out_vec
);

    localparam int W = tap_pkg::CORDIC_W;

    logic signed [W-1:0] x_reg [0:ITERS];
    logic signed [W-1:0] y_reg [0:ITERS];
    logic signed [W-1:0] z_reg [0:ITERS];
    logic                flip_reg [0:ITERS];
    tap_pkg::vec_t       vec_reg [0:ITERS];
    logic                vld_reg [0:ITERS];

    logic [31:0] phase;
    logic        flip_in;
    logic [31:0] phase_fold;

    // add a half turn; fold the left half plane by another half turn
    assign phase      = {in_item.torsion ^ 16'h8000, 16'h0000};
    assign flip_in    = phase[31] ^ phase[30];
    assign phase_fold = {phase[31] ^ flip_in, phase[30:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= tap_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(W-32){phase_fold[31]}}, phase_fold};
            flip_reg[0] <= flip_in;
            vec_reg[0]  <= in_item.vec;
        end
    end

    for (genvar i = 0; i < ITERS; i++)
    begin : g_iter
        logic signed [W-1:0] dx, dy, at;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        assign at = $signed({{(W-32){1'b0}}, tap_pkg::atan_turn(i)});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - at;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + at;
                end
                flip_reg[i+1] <= flip_reg[i];
                vec_reg[i+1]  <= vec_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[ITERS];
    assign out_x     = x_reg[ITERS];
    assign out_y     = y_reg[ITERS];
    assign out_flip  = flip_reg[ITERS];
    assign out_vec   = vec_reg[ITERS];

endmodule

@@ hw/rtl/tap_combine.sv @@
// Weight, cross product and weighted sum stages with the output register.
module tap_combine
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  tap_pkg::coef_t                       coef,
    input  logic                                 in_valid,
    input  logic signed [tap_pkg::CORDIC_W-1:0]  in_x,
    input  logic signed [tap_pkg::CORDIC_W-1:0]  in_y,
    input  logic                                 in_flip,
    input  tap_pkg::vec_t                        in_vec,
    output logic                                 out_valid,
    output logic signed [31:0]                   out_x,
    output logic signed [31:0]                   out_y,
    output logic signed [31:0]                   out_z,
    output logic                                 out_sat
);

    localparam int CW = tap_pkg::CORDIC_W;
    localparam int PW = tap_pkg::COEF_W + CW;   // coefficient times trig
    localparam int WW = PW - 30 + 1;            // rounded weight plus const term
    localparam int XW = 65 - 16;                // rounded cross component
    localparam int HW = XW - 24;                // upper cross part
    localparam int TW = WW + 32;                // weight times vector
    localparam int SW = WW + HW;                // weight times cross part
    localparam int AW = TW + 2;                 // accumulator
    localparam int RW = SW + 5;                 // final sum
    localparam logic signed [PW-1:0] HALF30 = PW'(64'sd536870912);
    localparam logic signed [64:0]   HALF16 = 65'sd32768;
    localparam logic signed [AW-1:0] HALF20 = AW'(64'sd524288);

    // stage 1
    logic signed [CW-1:0] c, s;
    logic signed [PW-1:0] pu_reg, pvc_reg, px_reg;
    logic signed [63:0]   m_pos_reg [3];
    logic signed [63:0]   m_neg_reg [3];
    logic signed [31:0]   ua1_reg [3];
    logic signed [31:0]   va1_reg [3];
    logic signed [tap_pkg::COEF_W-1:0] cvc1_reg;
    logic                 v1_reg, v2_reg, v3_reg;

    // stage 2
    logic signed [PW-1:0] ru, rv, rx;
    logic signed [WW-1:0] wu_reg, wv_reg, wx_reg;
    logic signed [XW-1:0] cr_reg [3];
    logic signed [31:0]   ua2_reg [3];
    logic signed [31:0]   va2_reg [3];

    // stage 3
    logic signed [TW-1:0] t1_reg [3];
    logic signed [TW-1:0] t2_reg [3];
    logic signed [SW-1:0] t3_reg [3];
    logic signed [SW-1:0] t4_reg [3];

    // stage 4
    logic signed [31:0]   res [3];
    logic                 clip [3];
    logic signed [31:0]   wx_out_reg, wy_out_reg, wz_out_reg;
    logic                 sat_reg, ov_reg;

    logic signed [31:0]   ua [3];
    logic signed [31:0]   va [3];

    assign ua[0] = in_vec.u_x;
    assign ua[1] = in_vec.u_y;
    assign ua[2] = in_vec.u_z;
    assign va[0] = in_vec.v_x;
    assign va[1] = in_vec.v_y;
    assign va[2] = in_vec.v_z;

    assign c = in_flip ? -in_x : in_x;
    assign s = in_flip ? -in_y : in_y;

    assign ru = pu_reg + HALF30;
    assign rv = pvc_reg + HALF30;
    assign rx = px_reg + HALF30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ov_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg   <= coef.coef_u * c;
            pvc_reg  <= coef.coef_v_cos * c;
            px_reg   <= coef.coef_cross * s;
            cvc1_reg <= coef.coef_v_const;
            // V x U: x = vy*uz - vz*uy, y = vz*ux - vx*uz, z = vx*uy - vy*ux
            m_pos_reg[0] <= va[1] * ua[2];
            m_neg_reg[0] <= va[2] * ua[1];
            m_pos_reg[1] <= va[2] * ua[0];
            m_neg_reg[1] <= va[0] * ua[2];
            m_pos_reg[2] <= va[0] * ua[1];
            m_neg_reg[2] <= va[1] * ua[0];
            ua1_reg <= ua;
            va1_reg <= va;

            wu_reg <= {ru[PW-1], ru[PW-1:30]};
            wv_reg <= {rv[PW-1], rv[PW-1:30]}
                      + {{(WW-tap_pkg::COEF_W){cvc1_reg[tap_pkg::COEF_W-1]}}, cvc1_reg};
            wx_reg <= {rx[PW-1], rx[PW-1:30]};
            ua2_reg <= ua1_reg;
            va2_reg <= va1_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_comp
        logic signed [64:0]   d;
        logic signed [HW-1:0] hi;
        logic signed [24:0]   lo;
        logic signed [AW-1:0] acc;
        logic signed [RW-1:0] r;

        assign d  = {m_pos_reg[k][63], m_pos_reg[k]} - {m_neg_reg[k][63], m_neg_reg[k]}
                    + HALF16;
        assign hi = cr_reg[k][XW-1:24];
        assign lo = {1'b0, cr_reg[k][23:0]};

        assign acc = {{(AW-TW){t1_reg[k][TW-1]}}, t1_reg[k]}
                   + {{(AW-TW){t2_reg[k][TW-1]}}, t2_reg[k]}
                   + {{(AW-SW){t3_reg[k][SW-1]}}, t3_reg[k]}
                   + HALF20;
        assign r = {{(RW-(AW-20)){acc[AW-1]}}, acc[AW-1:20]}
                 + {t4_reg[k][SW-1], t4_reg[k], 4'b0000};

        // clip to the 32-bit range
        always_comb
        begin
            clip[k] = 1'b0;
            res[k]  = r[31:0];
            if (!r[RW-1] && (r[RW-1:31] != '0))
            begin
                clip[k] = 1'b1;
                res[k]  = 32'sh7FFFFFFF;
            end
            else if (r[RW-1] && !(&r[RW-1:31]))
            begin
                clip[k] = 1'b1;
                res[k]  = 32'sh80000000;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cr_reg[k] <= d[64:16];
                t1_reg[k] <= wu_reg * ua2_reg[k];
                t2_reg[k] <= wv_reg * va2_reg[k];
                t3_reg[k] <= wx_reg * lo;
                t4_reg[k] <= wx_reg * hi;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_out_reg <= res[0];
            wy_out_reg <= res[1];
            wz_out_reg <= res[2];
            sat_reg    <= clip[0] | clip[1] | clip[2];
        end
    end

    assign out_valid = ov_reg;
    assign out_x     = wx_out_reg;
    assign out_y     = wy_out_reg;
    assign out_z     = wz_out_reg;
    assign out_sat   = sat_reg;

endmodule

@@ hw/rtl/torsion_atom_placement.sv @@
// Top level: coefficient registers, input queue, CORDIC and combine pipeline.
// Path: input queue, CORDIC of min(ANGLE_BITS, 24) iterations, combine stages, result valid.
// Throughput: one item per cycle unless a held result stalls; the CORDIC has one stage per iteration.
// Output stall on a valid result freezes the back pipeline; the two-entry input queue then fills.
// Reset (rst_n low, asynchronous) empties queue and pipeline, clears coefficients.
module torsion_atom_placement
#(
    parameter int ANGLE_BITS = tap_pkg::ANGLE_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [31:0]                u_x,
    input  logic signed [31:0]                u_y,
    input  logic signed [31:0]                u_z,
    input  logic signed [31:0]                v_x,
    input  logic signed [31:0]                v_y,
    input  logic signed [31:0]                v_z,
    input  logic [15:0]                       torsion,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [31:0]                w_x,
    output logic signed [31:0]                w_y,
    output logic signed [31:0]                w_z,
    output logic                              saturated,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tap_pkg::COEF_W-1:0]        cfg_data
);

    localparam int ITERS = (ANGLE_BITS < tap_pkg::ATAN_ENTRIES) ? ANGLE_BITS
                                                               : tap_pkg::ATAN_ENTRIES;

    tap_pkg::coef_t coef_reg, coef_next;
    tap_pkg::item_t in_item, head_item;
    tap_pkg::vec_t  cd_vec;
    logic           head_valid, en;
    logic           cd_valid, cd_flip;
    logic signed [tap_pkg::CORDIC_W-1:0] cd_x, cd_y;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tap_pkg::REG_COEF_U:       coef_next.coef_u       = cfg_data;
                tap_pkg::REG_COEF_V_CONST: coef_next.coef_v_const = cfg_data;
                tap_pkg::REG_COEF_V_COS:   coef_next.coef_v_cos   = cfg_data;
                tap_pkg::REG_COEF_CROSS:   coef_next.coef_cross   = cfg_data;
                default:                   coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign in_item.vec.u_x = u_x;
    assign in_item.vec.u_y = u_y;
    assign in_item.vec.u_z = u_z;
    assign in_item.vec.v_x = v_x;
    assign in_item.vec.v_y = v_y;
    assign in_item.vec.v_z = v_z;
    assign in_item.torsion = torsion;

    // back pipeline moves unless the finished result is held
    assign en = !out_valid || !out_stall;

    tap_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .head_valid (head_valid),
        .head_take  (en),
        .head_item  (head_item)
    );

    tap_cordic #(.ITERS(ITERS)) u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (head_valid),
        .in_item   (head_item),
        .out_valid (cd_valid),
        .out_x     (cd_x),
        .out_y     (cd_y),
        .out_flip  (cd_flip),
        .out_vec   (cd_vec)
    );

    tap_combine u_combine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .coef      (coef_reg),
        .in_valid  (cd_valid),
        .in_x      (cd_x),
        .in_y      (cd_y),
        .in_flip   (cd_flip),
        .in_vec    (cd_vec),
        .out_valid (out_valid),
        .out_x     (w_x),
        .out_y     (w_y),
        .out_z     (w_z),
        .out_sat   (saturated)
    );

endmodule

@@ test/torsion_atom_placement_tb.sv @@
// Self-checking testbench for the torsion atom placement block.
module torsion_atom_placement_tb;

    localparam int N_RANDOM  = 800;
    localparam int LATENCY   = tap_pkg::ANGLE_BITS_DEF + 6;
    localparam int MAX_CYC   = 400000;

    typedef struct {
        logic signed [31:0] w_x;
        logic signed [31:0] w_y;
        logic signed [31:0] w_z;
        logic               saturated;
    } placement_t;

    // Predicts the new bond vector and keeps the results still owed by the block.
    class placement_board;
        longint      cu, cvc, cvv, ccr;
        placement_t  owed[$];
        int          errors;

        function new();
            cu = 0; cvc = 0; cvv = 0; ccr = 0; errors = 0;
        endfunction

        function void set_coef(tap_pkg::cfg_reg_t idx, logic [23:0] val);
            longint sv;
            sv = longint'(signed'(val));
            case (idx)
                tap_pkg::REG_COEF_U:       cu = sv;
                tap_pkg::REG_COEF_V_CONST: cvc = sv;
                tap_pkg::REG_COEF_V_COS:   cvv = sv;
                tap_pkg::REG_COEF_CROSS:   ccr = sv;
                default: ;
            endcase
        endfunction

        function longint fsh(longint v, int s);
            return v >>> s;
        endfunction

        function longint rsh(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint comb(longint w1, longint a, longint w2, longint b,
                              longint wx, longint cr, ref bit sat);
            longint hi, lo, acc, r;
            hi  = cr >>> 24;
            lo  = cr & 64'hFFFFFF;
            acc = w1 * a + w2 * b + wx * lo + (longint'(1) << 19);
            r   = (acc >>> 20) + wx * hi * 16;
            if (r > 64'sd2147483647) begin sat = 1; r = 64'sd2147483647; end
            else if (r < -64'sd2147483648) begin sat = 1; r = -64'sd2147483648; end
            return r;
        endfunction

        function void note_input(logic signed [31:0] ux, logic signed [31:0] uy,
                                 logic signed [31:0] uz, logic signed [31:0] vx,
                                 logic signed [31:0] vy, logic signed [31:0] vz,
                                 logic [15:0] tor);
            logic [31:0] ph;
            bit          flip, sat;
            longint      x, y, z, dx, dy, wu, wv, wc, cx, cy, cz;
            longint      a0, a1, a2, b0, b1, b2;
            placement_t  p;
            ph   = {tor, 16'h0} + 32'h8000_0000;
            flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
            if (flip)
                ph += 32'h8000_0000;
            x = 652032874; y = 0;
            z = longint'(signed'(ph));
            for (int i = 0; i < tap_pkg::ANGLE_BITS_DEF && i < tap_pkg::ATAN_ENTRIES; i++)
            begin
                dx = fsh(y, i);
                dy = fsh(x, i);
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= longint'(tap_pkg::atan_turn(i));
                end
                else
                begin
                    x += dx; y -= dy; z += longint'(tap_pkg::atan_turn(i));
                end
            end
            if (flip)
            begin
                x = -x; y = -y;
            end
            a0 = ux; a1 = uy; a2 = uz; b0 = vx; b1 = vy; b2 = vz;
            wu = rsh(cu * x, 30);
            wv = rsh(cvc * (longint'(1) << 30) + cvv * x, 30);
            wc = rsh(ccr * y, 30);
            cx = rsh(b1 * a2 - b2 * a1, 16);
            cy = rsh(b2 * a0 - b0 * a2, 16);
            cz = rsh(b0 * a1 - b1 * a0, 16);
            sat = 0;
            p.w_x = 32'(comb(wu, a0, wv, b0, wc, cx, sat));
            p.w_y = 32'(comb(wu, a1, wv, b1, wc, cy, sat));
            p.w_z = 32'(comb(wu, a2, wv, b2, wc, cz, sat));
            p.saturated = sat;
            owed.push_back(p);
        endfunction

        function void check_result(logic signed [31:0] wx, logic signed [31:0] wy,
                                   logic signed [31:0] wz, logic sat);
            placement_t e;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result %h %h %h %b", $time, wx, wy, wz, sat);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (wx !== e.w_x)
            begin
                $display("%0t: w_x expected %h actual %h", $time, e.w_x, wx); errors++;
            end
            if (wy !== e.w_y)
            begin
                $display("%0t: w_y expected %h actual %h", $time, e.w_y, wy); errors++;
            end
            if (wz !== e.w_z)
            begin
                $display("%0t: w_z expected %h actual %h", $time, e.w_z, wz); errors++;
            end
            if (sat !== e.saturated)
            begin
                $display("%0t: saturated expected %b actual %b", $time, e.saturated, sat);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_stall, out_valid, out_stall = 0;
    logic signed [31:0] u_x = 0, u_y = 0, u_z = 0, v_x = 0, v_y = 0, v_z = 0;
    logic [15:0] torsion = 0;
    logic signed [31:0] w_x, w_y, w_z;
    logic saturated;
    logic cfg_valid = 0, cfg_ready;
    logic [tap_pkg::CFG_IDX_W-1:0] cfg_index = 0;
    logic [tap_pkg::COEF_W-1:0] cfg_data = 0;

    placement_board board = new();
    int send_idle = 0, recv_idle = 0;
    longint cycles = 0;

    torsion_atom_placement dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("torsion_atom_placement regression: fail");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
            board.check_result(w_x, w_y, w_z, saturated);
    end

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < recv_idle);

    task automatic write_coef(tap_pkg::cfg_reg_t idx, logic [23:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        board.set_coef(idx, val);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    task automatic send_item(logic [31:0] ux, logic [31:0] uy, logic [31:0] uz,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [15:0] tor);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        u_x <= ux; u_y <= uy; u_z <= uz;
        v_x <= vx; v_y <= vy; v_z <= vz;
        torsion <= tor;
        do @(posedge clk); while (in_stall);
        board.note_input(ux, uy, uz, vx, vy, vz, tor);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_vec(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(32'h0004_0000) - 32'h0002_0000; // about +-2.0
            default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic logic [23:0] rand_coef(int mode);
        case (mode)
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h0;
            default: return 24'($urandom());
        endcase
    endfunction

    initial
    begin
        int m;
        logic [31:0] ext [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // zero coefficients first, then typical bond geometry
        send_item(32'h10000, 0, 0, 0, 32'h10000, 0, 16'h0);
        drain();
        write_coef(tap_pkg::REG_COEF_U, 24'h080000);
        write_coef(tap_pkg::REG_COEF_V_CONST, 24'h180000);
        write_coef(tap_pkg::REG_COEF_V_COS, 24'hF40000);
        write_coef(tap_pkg::REG_COEF_CROSS, 24'h0DDB3D);
        foreach (ext[i])
            send_item(ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4], ext[i],
                      ext[(i+1)%4], 16'(i * 16'h4000));
        for (int t = 0; t < 8; t++)
            send_item(32'h10000, 32'h8000, 32'hFFFF0000, 32'h4000, 32'h10000,
                      32'h20000, 16'(t * 16'h2000 + (t & 1)));
        send_item(32'h10000, 0, 0, 0, 32'h10000, 0, 16'hFFFF);
        send_item(32'h10000, 0, 0, 0, 32'h10000, 0, 16'h7FFF);
        send_item(32'h10000, 0, 0, 0, 32'h10000, 0, 16'h8001);
        drain();
        // extreme coefficients drive saturation
        write_coef(tap_pkg::REG_COEF_U, 24'h7FFFFF);
        write_coef(tap_pkg::REG_COEF_V_CONST, 24'h800000);
        write_coef(tap_pkg::REG_COEF_V_COS, 24'h7FFFFF);
        write_coef(tap_pkg::REG_COEF_CROSS, 24'h800000);
        foreach (ext[i])
            send_item(ext[i], ext[3-i], ext[i], ext[(i+1)%4], ext[(i+2)%4],
                      ext[3-i], 16'($urandom()));
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 3)      begin send_idle = 30; recv_idle = 59; end
            else if (ph < 6) begin send_idle = 59; recv_idle = 30; end
            else             begin send_idle = 0;  recv_idle = 0;  end
            write_coef(tap_pkg::REG_COEF_U, rand_coef(ph % 4));
            write_coef(tap_pkg::REG_COEF_V_CONST, rand_coef((ph + 1) % 4));
            write_coef(tap_pkg::REG_COEF_V_COS, rand_coef((ph + 2) % 4));
            write_coef(tap_pkg::REG_COEF_CROSS, rand_coef((ph + 3) % 4));
            for (int n = 0; n < N_RANDOM / 8; n++)
            begin
                m = $urandom_range(2);
                send_item(rand_vec(m), rand_vec(m), rand_vec(m), rand_vec(m),
                          rand_vec(m), rand_vec(m), 16'($urandom()));
            end
            drain();
        end

        if (board.errors == 0 && board.owed.size() == 0)
            $display("torsion_atom_placement regression: pass");
        else
            $display("torsion_atom_placement regression: fail");
        $finish;
    end
endmodule
